// ----- design/frc_pkg.sv -----
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the framed packet receive checker: byte tags,
// frame status codes, framing codes and CRC-16/MODBUS constants.
// ----------------------------------------------------------------------------
package frc_pkg;

    // Framing codes
    localparam logic [7:0]  START_CODE = 8'h02;
    localparam logic [7:0]  END_CODE   = 8'h03;

    // CRC-16/MODBUS: reflected polynomial, start value, no final xor
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // Place of a byte in the frame
    typedef enum logic [3:0] {
        KIND_START   = 4'd0,
        KIND_CONTROL = 4'd1,
        KIND_COUNT   = 4'd2,
        KIND_TERM    = 4'd3,
        KIND_PAYLOAD = 4'd4,
        KIND_CRC_LO  = 4'd5,
        KIND_CRC_HI  = 4'd6,
        KIND_END     = 4'd7,
        KIND_NONE    = 4'd8
    } t_kind;

    // Frame status, valid on the closing beat
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_LARGE      = 3'd2,
        ST_NO_START   = 3'd3,
        ST_NO_END     = 3'd4,
        ST_BAD_COUNT  = 3'd5,
        ST_COUNT_MISM = 3'd6,
        ST_CRC_MISM   = 3'd7
    } t_status;

endpackage

// ----- design/frc_crc_step.sv -----
// ----------------------------------------------------------------------------
// frc_crc_step
// One byte of CRC-16/MODBUS: xor the byte into the low end, then eight
// reflected shift steps against the polynomial.
// ----------------------------------------------------------------------------
module frc_crc_step
    import frc_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    // Bitwise reflected update, eight dependent steps
    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {8'h00, i_data};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

// ----- design/framed_packet_receive_checker.sv -----
// ----------------------------------------------------------------------------
// framed_packet_receive_checker
// Receive-side checker for STX/ETX framed packets with a CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one wire byte per beat, with
//   i_last_byte set on the final byte of a frame. Output channel
//   (o_valid / i_stall) returns one beat per input beat: the byte unchanged,
//   its tag (start, control, count, terminal id, payload, crc low/high, end,
//   unplaced), and on the closing beat o_frame_end with the frame status.
//   Payload is not buffered; the consumer commits or drops it on the status.
// Output: an accepted input beat reaches o_valid in the cycle after it is taken.
// Throughput: one byte per cycle unless stalled; the bytewise CRC update and the
//   position compares sit between the frame state registers and the output register.
// Reset: synchronous, active low; clears the frame state (position, count,
//   CRC, start flag) and empties the output register. State also returns to
//   its reset value after each last byte.
// Stall: while i_stall holds a full output register, o_stall is raised and
//   the held beat stays unchanged; a beat is taken in the same cycle the
//   output register drains, so there is no bubble.
// ----------------------------------------------------------------------------
module framed_packet_receive_checker
    import frc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES   = 256,
    parameter int TERMINAL_ID_BYTES = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_out,
    output logic [3:0] o_byte_kind,
    output logic       o_frame_end,
    output logic [2:0] o_status
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    // compare width covers count + 2 and the saturated position + 1
    localparam logic [9:0] MAX_POS   = 10'(MAX_FRAME_BYTES);
    localparam logic [9:0] TERM_END  = 10'(3 + TERMINAL_ID_BYTES);
    localparam logic [9:0] MIN_SIZE  = 10'(TERMINAL_ID_BYTES + 6);
    localparam logic [7:0] MIN_COUNT = 8'(TERMINAL_ID_BYTES + 3);

    // frame state
    logic [PW-1:0] r_pos,     n_pos;
    logic [7:0]    r_count,   n_count;
    logic [15:0]   r_crc,     n_crc;
    logic [15:0]   r_rx_crc,  n_rx_crc;
    logic          r_start_ok, n_start_ok;

    // output register
    logic          r_valid;
    logic [7:0]    r_byte;
    t_kind         r_kind;
    logic          r_end;
    t_status       r_status;

    t_kind         kind;
    t_status       status;
    logic          accept;
    logic [15:0]   crc_upd;
    logic [9:0]    pos_w;
    logic [9:0]    cnt_w;
    logic [9:0]    size_w;

    // handshake: take a beat when the output register is empty or draining
    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    frc_crc_step u_crc (
        .i_crc  (r_crc),
        .i_data (i_data_byte),
        .o_crc  (crc_upd)
    );

    assign pos_w  = 10'(r_pos);
    assign cnt_w  = 10'(r_count);
    assign size_w = pos_w + 10'd1;

    // tag by position against the stored count
    always_comb begin
        if (pos_w >= MAX_POS) begin
            kind = KIND_NONE;
        end else if (pos_w == 10'd0) begin
            kind = KIND_START;
        end else if (pos_w == 10'd1) begin
            kind = KIND_CONTROL;
        end else if (pos_w == 10'd2) begin
            kind = KIND_COUNT;
        end else if (pos_w < TERM_END) begin
            kind = KIND_TERM;
        end else if (r_count < MIN_COUNT) begin
            kind = KIND_NONE;
        end else if (pos_w < cnt_w) begin
            kind = KIND_PAYLOAD;
        end else if (pos_w == cnt_w) begin
            kind = KIND_CRC_LO;
        end else if (pos_w == cnt_w + 10'd1) begin
            kind = KIND_CRC_HI;
        end else if (pos_w == cnt_w + 10'd2) begin
            kind = KIND_END;
        end else begin
            kind = KIND_NONE;
        end
    end

    // field capture and CRC update
    always_comb begin
        n_start_ok = r_start_ok;
        n_count    = r_count;
        n_rx_crc   = r_rx_crc;
        n_crc      = r_crc;
        case (kind)
            KIND_START:   n_start_ok = (i_data_byte == START_CODE);
            KIND_COUNT:   n_count    = i_data_byte;
            KIND_CRC_LO:  n_rx_crc   = {r_rx_crc[15:8], i_data_byte};
            KIND_CRC_HI:  n_rx_crc   = {i_data_byte, r_rx_crc[7:0]};
            default:      ;
        endcase
        if (kind inside {KIND_CONTROL, KIND_COUNT, KIND_TERM, KIND_PAYLOAD}) begin
            n_crc = crc_upd;
        end
    end

    // status checks in priority order, on the closing beat only
    always_comb begin
        if (!i_last_byte) begin
            status = ST_OK;
        end else if (size_w < MIN_SIZE) begin
            status = ST_SHORT;
        end else if (size_w > MAX_POS) begin
            status = ST_LARGE;
        end else if (!n_start_ok) begin
            status = ST_NO_START;
        end else if (i_data_byte != END_CODE) begin
            status = ST_NO_END;
        end else if (n_count < MIN_COUNT) begin
            status = ST_BAD_COUNT;
        end else if (size_w != 10'(n_count) + 10'd3) begin
            status = ST_COUNT_MISM;
        end else if (n_rx_crc != n_crc) begin
            status = ST_CRC_MISM;
        end else begin
            status = ST_OK;
        end
    end

    // next position: saturate; the frame state registers restart it after the last byte
    always_comb begin
        if (pos_w < MAX_POS) begin
            n_pos = r_pos + PW'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_count    <= '0;
            r_crc      <= CRC_INIT;
            r_rx_crc   <= '0;
            r_start_ok <= 1'b0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_pos      <= '0;
                r_count    <= '0;
                r_crc      <= CRC_INIT;
                r_rx_crc   <= '0;
                r_start_ok <= 1'b0;
            end else begin
                r_pos      <= n_pos;
                r_count    <= n_count;
                r_crc      <= n_crc;
                r_rx_crc   <= n_rx_crc;
                r_start_ok <= n_start_ok;
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte   <= i_data_byte;
            r_kind   <= kind;
            r_end    <= i_last_byte;
            r_status <= status;
        end
    end

    assign o_valid     = r_valid;
    assign o_byte_out  = r_byte;
    assign o_byte_kind = r_kind;
    assign o_frame_end = r_end;
    assign o_status    = r_status;

endmodule

// ----- dv/framed_packet_receive_checker_tb.sv -----
// ----------------------------------------------------------------------------
// framed_packet_receive_checker_tb
// Self-checking bench for the STX/ETX frame receive checker. Frames are built
// with random content, either well formed or with one fault (bad start, bad
// end, low count, count off, CRC error, cut short, extra bytes, noise), and
// streamed one beat per byte. A local tag and CRC-16/MODBUS predictor gives the
// expected tag and status of every byte, and the monitor compares each output
// beat field by field. Random idle and stall phases run on both channels.
// ----------------------------------------------------------------------------
module framed_packet_receive_checker_tb;
    import frc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES = 256;
    localparam int TID_BYTES = 5;
    localparam int MIN_COUNT = TID_BYTES + 3;
    localparam int MIN_SIZE  = TID_BYTES + 6;

    // Ways a generated frame can be damaged
    typedef enum int {
        FLT_NONE, FLT_START, FLT_END, FLT_COUNT_LOW, FLT_COUNT_OFF,
        FLT_CRC, FLT_TRUNC, FLT_EXTEND, FLT_NOISE
    } t_fault;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_wire_beat;

    typedef struct {
        logic [7:0] data;
        t_kind      kind;
        logic       frame_end;
        t_status    status;
    } t_tagged_beat;

    // DUT signals, known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_byte_out;
    logic [3:0] o_byte_kind;
    logic       o_frame_end;
    logic [2:0] o_status;

    t_wire_beat   wire_beats_q[$];
    t_tagged_beat tagged_expect_q[$];
    t_wire_beat   next_beat;
    int           beats_queued   = 0;
    int           err_count      = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    // Predictor state of the frame being received
    int unsigned  frm_pos;
    logic [7:0]   frm_count;
    logic [15:0]  frm_crc;
    logic [15:0]  frm_rx_crc;
    bit           frm_start_ok;

    framed_packet_receive_checker #(
        .MAX_FRAME_BYTES   (MAX_BYTES),
        .TERMINAL_ID_BYTES (TID_BYTES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_byte_out  (o_byte_out),
        .o_byte_kind (o_byte_kind),
        .o_frame_end (o_frame_end),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the pipe hangs
    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] crc16_arc_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_kind kind_at(int unsigned p, logic [7:0] cnt_byte);
        int unsigned c;
        c = cnt_byte;
        if (p >= MAX_BYTES)     return KIND_NONE;
        if (p == 0)             return KIND_START;
        if (p == 1)             return KIND_CONTROL;
        if (p == 2)             return KIND_COUNT;
        if (p < 3 + TID_BYTES)  return KIND_TERM;
        if (c < MIN_COUNT)      return KIND_NONE;
        if (p < c)              return KIND_PAYLOAD;
        if (p == c)             return KIND_CRC_LO;
        if (p == c + 1)         return KIND_CRC_HI;
        if (p == c + 2)         return KIND_END;
        return KIND_NONE;
    endfunction

    function automatic void clear_frame_state();
        frm_pos      = 0;
        frm_count    = 8'h00;
        frm_crc      = CRC_INIT;
        frm_rx_crc   = 16'h0000;
        frm_start_ok = 1'b0;
    endfunction

    // Tag one accepted byte, close the frame on the last one
    function automatic void tag_and_check_byte(logic [7:0] b, logic last);
        t_tagged_beat exp_beat;
        t_kind        k;
        int unsigned  size;
        k = kind_at(frm_pos, frm_count);
        case (k)
            KIND_START:  frm_start_ok = (b == START_CODE);
            KIND_COUNT:  frm_count = b;
            KIND_CRC_LO: frm_rx_crc[7:0] = b;
            KIND_CRC_HI: frm_rx_crc[15:8] = b;
            default: ;
        endcase
        if (k == KIND_CONTROL || k == KIND_COUNT || k == KIND_TERM || k == KIND_PAYLOAD)
            frm_crc = crc16_arc_update(frm_crc, b);

        exp_beat.data      = b;
        exp_beat.kind      = k;
        exp_beat.frame_end = last;
        exp_beat.status    = ST_OK;
        if (last) begin
            size = frm_pos + 1;
            if (size < MIN_SIZE)                     exp_beat.status = ST_SHORT;
            else if (size > MAX_BYTES)               exp_beat.status = ST_LARGE;
            else if (!frm_start_ok)                  exp_beat.status = ST_NO_START;
            else if (b != END_CODE)                  exp_beat.status = ST_NO_END;
            else if (int'(frm_count) < MIN_COUNT)    exp_beat.status = ST_BAD_COUNT;
            else if (size != int'(frm_count) + 3)    exp_beat.status = ST_COUNT_MISM;
            else if (frm_rx_crc != frm_crc)          exp_beat.status = ST_CRC_MISM;
        end
        tagged_expect_q = {tagged_expect_q, exp_beat};

        if (last)
            clear_frame_state();
        else if (frm_pos < MAX_BYTES)
            frm_pos++;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_beat(logic [7:0] b, logic last);
        t_wire_beat wb;
        wb.data = b;
        wb.last = last;
        wire_beats_q = {wire_beats_q, wb};
        beats_queued++;
    endfunction

    // Build one frame with pay_len payload bytes and the given fault
    function automatic void build_frame(int pay_len, t_fault fault);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        int          cnt;
        int          cnt_wire;
        int          cut;
        cnt = MIN_COUNT + pay_len;
        case (fault)
            FLT_COUNT_LOW: cnt_wire = $urandom_range(MIN_COUNT - 1);
            FLT_COUNT_OFF: begin
                if ($urandom_range(1) == 1 && cnt >= MIN_COUNT + 4)
                    cnt_wire = cnt - 1 - $urandom_range(3);
                else
                    cnt_wire = cnt + 1 + $urandom_range(3);
            end
            default:       cnt_wire = (cnt > 255) ? 255 : cnt;
        endcase

        fb = {fb, START_CODE};
        fb = {fb, 8'($urandom)};
        fb = {fb, 8'(cnt_wire)};
        for (int i = 0; i < TID_BYTES + pay_len; i++)
            fb = {fb, 8'($urandom)};
        crc = CRC_INIT;
        for (int i = 1; i < fb.size(); i++)
            crc = crc16_arc_update(crc, fb[i]);
        if (fault == FLT_CRC)
            crc ^= 16'(1 << $urandom_range(15));
        fb = {fb, crc[7:0]};
        fb = {fb, crc[15:8]};
        fb = {fb, END_CODE};

        case (fault)
            FLT_START: fb[0] = START_CODE ^ 8'(1 + $urandom_range(254));
            FLT_END:   fb[fb.size()-1] = END_CODE ^ 8'(1 + $urandom_range(254));
            FLT_TRUNC: begin
                cut = $urandom_range(1, fb.size() - 1);
                while (fb.size() > cut) void'(fb.pop_back());
            end
            FLT_EXTEND: begin
                repeat ($urandom_range(1, 6)) fb = {fb, 8'($urandom)};
            end
            FLT_NOISE: begin
                fb = {};
                repeat ($urandom_range(1, 24)) fb = {fb, 8'($urandom)};
            end
            default: ;
        endcase

        foreach (fb[i])
            add_beat(fb[i], i == fb.size() - 1);
    endfunction

    function automatic void random_frame();
        int     r;
        int     pay_len;
        t_fault fault;
        r = $urandom_range(99);
        if (r < 45)      fault = FLT_NONE;
        else if (r < 52) fault = FLT_START;
        else if (r < 59) fault = FLT_END;
        else if (r < 66) fault = FLT_COUNT_LOW;
        else if (r < 73) fault = FLT_COUNT_OFF;
        else if (r < 81) fault = FLT_CRC;
        else if (r < 88) fault = FLT_TRUNC;
        else if (r < 94) fault = FLT_EXTEND;
        else             fault = FLT_NOISE;
        pay_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
        build_frame(pay_len, fault);
    endfunction

    task automatic wait_drained();
        while (wire_beats_q.size() != 0 || i_valid || tagged_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: one byte per beat, holds the beat while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_data_byte <= 8'h00;
            i_last_byte <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                tag_and_check_byte(i_data_byte, i_last_byte);
            if (!i_valid || !o_stall) begin
                if (wire_beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = wire_beats_q.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= next_beat.data;
                    i_last_byte <= next_beat.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each output beat with the oldest expectation
    // ------------------------------------------------------------------
    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] ERROR %s", $realtime, msg);
    endfunction

    function automatic void check_beat();
        t_tagged_beat exp_beat;
        if (tagged_expect_q.size() == 0) begin
            flag_error($sformatf("unexpected beat byte=%02h kind=%0d end=%0b st=%0d",
                                 o_byte_out, o_byte_kind, o_frame_end, o_status));
            return;
        end
        exp_beat = tagged_expect_q.pop_front();
        if (o_byte_out !== exp_beat.data || o_byte_kind !== exp_beat.kind ||
            o_frame_end !== exp_beat.frame_end || o_status !== exp_beat.status)
            flag_error($sformatf(
                {"beat mismatch exp byte=%02h kind=%0d end=%0b st=%0d ",
                 "got byte=%02h kind=%0d end=%0b st=%0d"},
                exp_beat.data, exp_beat.kind, exp_beat.frame_end, exp_beat.status,
                o_byte_out, o_byte_kind, o_frame_end, o_status));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_beat();
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed frames, then four idle/stall phases
    // ------------------------------------------------------------------
    initial begin
        int phase_start;
        clear_frame_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-byte frame, shortest good frame, bad start byte
        add_beat(8'hFF, 1'b1);
        build_frame(0, FLT_NONE);
        build_frame(0, FLT_START);

        for (int ph = 0; ph < 4; ph++) begin
            @(negedge i_clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            phase_start = beats_queued;
            while (beats_queued - phase_start < 115)
                random_frame();
            // Largest good frame, and a frame past the size limit
            if (ph == 1) build_frame(MAX_BYTES - MIN_SIZE, FLT_NONE);
            if (ph == 3) build_frame(MAX_BYTES - MIN_SIZE + 1 + $urandom_range(40), FLT_NONE);
            // Sender holds off until every result of the phase is back
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (tagged_expect_q.size() != 0)
            flag_error($sformatf("%0d beats never came out", tagged_expect_q.size()));
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
